// ----- sv/msc_pkg.sv -----
`timescale 1ns / 1ps

package msc_pkg;

  localparam int unsigned LINES_DEF = 2;

  localparam int unsigned ADDR_W = 8;
  localparam int unsigned DATA_W = 8;

  // operation codes
  localparam logic [2:0] OP_CPU_RD    = 3'd0;
  localparam logic [2:0] OP_CPU_WR    = 3'd1;
  localparam logic [2:0] OP_SNP_RD    = 3'd2;
  localparam logic [2:0] OP_SNP_INV   = 3'd3;
  localparam logic [2:0] OP_SNP_SHARE = 3'd4;
  localparam logic [2:0] OP_SNP_FLUSH = 3'd5;

  // mesi states
  localparam logic [1:0] ST_M = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_S = 2'd2;
  localparam logic [1:0] ST_I = 2'd3;

  // bus transaction types
  localparam logic [1:0] BUS_RD    = 2'd0;
  localparam logic [1:0] BUS_RDX   = 2'd1;
  localparam logic [1:0] BUS_SHARE = 2'd2;
  localparam logic [1:0] BUS_FLUSH = 2'd3;

  typedef struct packed {
    logic [2:0]               operation;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_value;
    logic signed [DATA_W-1:0] fill_data;
    logic [1:0]               issuer_id;
  } req_t;

  typedef struct packed {
    logic                     writeback_valid;
    logic [ADDR_W-1:0]        writeback_address;
    logic signed [DATA_W-1:0] writeback_value;
    logic                     bus_valid;
    logic [1:0]               bus_type;
    logic [ADDR_W-1:0]        bus_address;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               line_state;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic [DATA_W-1:0] value;
    logic [1:0]        mesi;
  } line_t;

endpackage

// ----- sv/mesi_snooping_cache_controller.sv -----
`timescale 1ns / 1ps

// mesi cache controller for one core, direct mapped, LINES lines
// request channel: drive req_i and pulse start_i; a transaction is taken at
//   every edge where start_i is high and busy_o is low. busy_o never rises,
//   so a cpu access or a snoop can be issued in every cycle.
// result channel: done_o is high for exactly one cycle with rsp_o; the result
//   of a transaction is computed from the s1 stage and registered into rsp_q
//   and done_q before it appears on rsp_o. the receiver cannot stall, so
//   results are never held back and throughput is one transaction per cycle.
// the line store is read when a transaction is accepted and written in the
//   cycle after; a forwarding register covers back-to-back hits to one line.
// configuration: core_id is written over cfg_valid_i/cfg_ready_o, by the user
//   only while the block is idle (not enforced); cfg_ready_o is always high.
// reset: all lines read as tag 0, value 0, invalid (per-line valid bits are
//   cleared), core_id goes to 0 and any transaction in flight is dropped.
//   no clearing pass is needed, the block accepts work right after reset.
module mesi_snooping_cache_controller #(
  parameter int unsigned LINES = msc_pkg::LINES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  msc_pkg::req_t  req_i,
  output logic           done_o,
  output msc_pkg::rsp_t  rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_data_i
);
  import msc_pkg::*;

  localparam int unsigned IdxW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned AddrN = 1 << ADDR_W;

  // address to line index table, built at elaboration
  logic [IdxW-1:0] idx_lut [AddrN];
  for (genvar g = 0; g < AddrN; g++) begin : g_lut
    assign idx_lut[g] = IdxW'(g % LINES);
  end

  line_t            mem [LINES];
  logic [LINES-1:0] lvld_q;

  logic [1:0]      core_id_q;
  logic            accept;
  logic [IdxW-1:0] in_idx;

  logic            s1_vld_q;
  req_t            s1_req_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_lvld_q;
  line_t           s1_line_q;

  logic            wr_vld_q;
  logic [IdxW-1:0] wr_idx_q;
  line_t           wr_line_q;

  line_t line_cur;
  line_t line_nxt;
  rsp_t  rsp_d;
  rsp_t  rsp_q;
  logic  done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign in_idx      = idx_lut[req_i.address];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      core_id_q <= cfg_data_i;
    end
  end

  // line store: read on accept, write from the update stage
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      mem[s1_idx_q] <= line_nxt;
    end
    if (accept) begin
      s1_line_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q   <= '0;
      s1_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (s1_vld_q) begin
        lvld_q[s1_idx_q] <= 1'b1;
      end
      s1_vld_q <= accept;
      wr_vld_q <= s1_vld_q;
      done_q   <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= req_i;
      s1_idx_q  <= in_idx;
      s1_lvld_q <= lvld_q[in_idx];
    end
    wr_idx_q  <= s1_idx_q;
    wr_line_q <= line_nxt;
    rsp_q     <= rsp_d;
  end

  // the store read missed the write of the previous transaction when both
  // address the same line, so take the forwarded copy
  always_comb begin
    if (wr_vld_q && (wr_idx_q == s1_idx_q)) begin
      line_cur = wr_line_q;
    end else if (s1_lvld_q) begin
      line_cur = s1_line_q;
    end else begin
      line_cur      = '0;
      line_cur.mesi = ST_I;
    end
  end

  msc_core u_core (
    .req_i     (s1_req_q),
    .line_i    (line_cur),
    .core_id_i (core_id_q),
    .line_o    (line_nxt),
    .rsp_o     (rsp_d)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- sv/msc_core.sv -----
`timescale 1ns / 1ps

module msc_core (
  input  msc_pkg::req_t  req_i,
  input  msc_pkg::line_t line_i,
  input  logic [1:0]     core_id_i,
  output msc_pkg::line_t line_o,
  output msc_pkg::rsp_t  rsp_o
);
  import msc_pkg::*;

  logic hit;
  logic is_cpu;
  logic snp_act;

  assign hit     = (line_i.tag == req_i.address);
  assign is_cpu  = (req_i.operation == OP_CPU_RD) || (req_i.operation == OP_CPU_WR);
  assign snp_act = (req_i.operation == OP_SNP_RD) || (req_i.operation == OP_SNP_INV) ||
                   (req_i.operation == OP_SNP_SHARE) || (req_i.operation == OP_SNP_FLUSH);

  always_comb begin
    line_o = line_i;
    rsp_o  = '0;
    if (is_cpu) begin
      if (!hit) begin
        if (line_i.mesi == ST_M) begin
          rsp_o.writeback_valid   = 1'b1;
          rsp_o.writeback_address = line_i.tag;
          rsp_o.writeback_value   = line_i.value;
        end
        line_o.tag = req_i.address;
        rsp_o.bus_valid   = 1'b1;
        rsp_o.bus_address = req_i.address;
        if (req_i.operation == OP_CPU_RD) begin
          line_o.value   = req_i.fill_data;
          line_o.mesi    = ST_E;
          rsp_o.bus_type = BUS_RD;
        end else begin
          line_o.value   = req_i.write_value;
          line_o.mesi    = ST_M;
          rsp_o.bus_type = BUS_RDX;
        end
      end else if (req_i.operation == OP_CPU_RD) begin
        // read hit on an invalid line refills without a victim
        if (line_i.mesi == ST_I) begin
          line_o.value      = req_i.fill_data;
          line_o.mesi       = ST_E;
          rsp_o.bus_valid   = 1'b1;
          rsp_o.bus_type    = BUS_RD;
          rsp_o.bus_address = req_i.address;
        end
      end else begin
        line_o.value = req_i.write_value;
        line_o.mesi  = ST_M;
        if (line_i.mesi != ST_M) begin
          rsp_o.bus_valid   = 1'b1;
          rsp_o.bus_type    = BUS_RDX;
          rsp_o.bus_address = req_i.address;
        end
      end
    end else if (snp_act && (req_i.issuer_id != core_id_i) && hit && (line_i.mesi != ST_I)) begin
      case (req_i.operation)
        OP_SNP_RD: begin
          rsp_o.bus_valid   = 1'b1;
          rsp_o.bus_address = req_i.address;
          if (line_i.mesi == ST_M) begin
            rsp_o.writeback_valid   = 1'b1;
            rsp_o.writeback_address = line_i.tag;
            rsp_o.writeback_value   = line_i.value;
            rsp_o.bus_type          = BUS_FLUSH;
          end else begin
            rsp_o.bus_type = BUS_SHARE;
          end
          line_o.mesi = ST_S;
        end
        OP_SNP_INV: begin
          line_o.mesi = ST_I;
        end
        OP_SNP_SHARE: begin
          line_o.mesi = ST_S;
        end
        default: begin
          if (line_i.mesi == ST_E) begin
            line_o.value = req_i.fill_data;
            line_o.mesi  = ST_S;
          end
        end
      endcase
    end

    if (line_o.tag == req_i.address) begin
      rsp_o.read_value = line_o.value;
      rsp_o.line_state = line_o.mesi;
    end else begin
      rsp_o.read_value = '0;
      rsp_o.line_state = ST_I;
    end
  end

endmodule
